[rtl/ibps_pkg.sv]
// Shared types, codes and sizes for the IR burst pair sequencer.
package ibps_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int SLOT_W = 8;
  localparam int DUR_W = 16;
  localparam int PAIRS_W = 7;
  localparam int TOTAL_W = 32;
  // Wide enough for both the slot field and any table address.
  localparam int IDX_W = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;
  // Pattern end: twice the sum of two 7-bit counts, or the table depth.
  localparam int PEND_W = ((ADDR_W + 1) > (PAIRS_W + 2)) ? (ADDR_W + 1) : (PAIRS_W + 2);
  localparam logic [TOTAL_W-1:0] STOP_LIMIT_RST = 32'd40000;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_INTRO  = 2'd0,
    REG_REPEAT = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic capture;  // latch the incoming transaction, write the table on a load
    logic exec;     // apply the item and load the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic                 we;
    reg_idx_t             idx;
    logic [PDATA_W-1:0]   data;
  } cfg_wr_t;

  typedef struct packed {
    logic [PAIRS_W-1:0]   intro_pairs;
    logic [PAIRS_W-1:0]   repeat_pairs;
    logic [TOTAL_W-1:0]   stop_limit;
  } cfg_regs_t;

endpackage

[rtl/ibps_ctrl.sv]
// Controller state machine: input and output handshakes and item sequencing.
module ibps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ibps_pkg::ctl_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    ctl.capture = 1'b0;
    ctl.exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      // The table word at the current position is fetched during this cycle.
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          ctl.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.exec) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/ibps_dp.sv]
// Datapath: burst table memory, counters, configuration registers, result register.
module ibps_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ibps_pkg::ctl_cmd_t            ctl,
  input  ibps_pkg::cfg_wr_t             cfg_wr,
  output ibps_pkg::cfg_regs_t           cfg,
  input  logic [1:0]                    cmd,
  input  logic [ibps_pkg::SLOT_W-1:0]   slot,
  input  logic [ibps_pkg::DUR_W-1:0]    duration,
  output logic                          led_on,
  output logic                          busy_res,
  output logic                          toggled,
  output logic                          done_res
);

  logic [ibps_pkg::DUR_W-1:0]   burst_table [ibps_pkg::TABLE_DEPTH];
  logic [ibps_pkg::DUR_W-1:0]   entry;

  ibps_pkg::cmd_t               cmd_q;

  logic [ibps_pkg::ADDR_W-1:0]  position;
  logic [ibps_pkg::DUR_W-1:0]   burst_count;
  logic [ibps_pkg::TOTAL_W-1:0] total_count;
  logic                         led_level;
  logic                         running;

  logic [ibps_pkg::ADDR_W-1:0]  position_next;
  logic [ibps_pkg::DUR_W-1:0]   burst_count_next;
  logic [ibps_pkg::TOTAL_W-1:0] total_count_next;
  logic                         led_level_next;
  logic                         running_next;
  logic                         toggled_next;
  logic                         done_next;

  logic [ibps_pkg::IDX_W:0]     slot_wide;
  logic [ibps_pkg::PAIRS_W+1:0] end_raw;
  logic [ibps_pkg::PAIRS_W+1:0] rep_raw;
  logic [ibps_pkg::PEND_W-1:0]  pat_end;
  logic [ibps_pkg::PEND_W-1:0]  rep_start;
  logic [ibps_pkg::PEND_W-1:0]  pos_inc;
  logic [ibps_pkg::DUR_W-1:0]   count_inc;
  logic [ibps_pkg::TOTAL_W-1:0] total_inc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.intro_pairs  <= '0;
      cfg.repeat_pairs <= '0;
      cfg.stop_limit   <= ibps_pkg::STOP_LIMIT_RST;
    end else if (cfg_wr.we) begin
      case (cfg_wr.idx)
        ibps_pkg::REG_INTRO:  cfg.intro_pairs  <= cfg_wr.data[ibps_pkg::PAIRS_W-1:0];
        ibps_pkg::REG_REPEAT: cfg.repeat_pairs <= cfg_wr.data[ibps_pkg::PAIRS_W-1:0];
        ibps_pkg::REG_LIMIT:  cfg.stop_limit   <= cfg_wr.data[ibps_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Burst table. Loads are written on capture, so the read in the following
  // cycle already sees the new word.
  assign slot_wide = (ibps_pkg::IDX_W + 1)'(slot);

  always_ff @(posedge clk) begin
    if (ctl.capture && (ibps_pkg::cmd_t'(cmd) == ibps_pkg::CMD_LOAD) &&
        (slot_wide < (ibps_pkg::IDX_W + 1)'(ibps_pkg::TABLE_DEPTH))) begin
      burst_table[slot_wide[ibps_pkg::ADDR_W-1:0]] <= duration;
    end
    entry <= burst_table[position];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= ibps_pkg::cmd_t'(cmd);
    end
  end

  // Pattern bounds, both limited to the table depth.
  assign end_raw = {(ibps_pkg::PAIRS_W + 1)'(cfg.intro_pairs) +
                    (ibps_pkg::PAIRS_W + 1)'(cfg.repeat_pairs), 1'b0};
  assign rep_raw = {1'b0, cfg.intro_pairs, 1'b0};

  always_comb begin
    if (ibps_pkg::PEND_W'(end_raw) > ibps_pkg::PEND_W'(ibps_pkg::TABLE_DEPTH)) begin
      pat_end = ibps_pkg::PEND_W'(ibps_pkg::TABLE_DEPTH);
    end else begin
      pat_end = ibps_pkg::PEND_W'(end_raw);
    end
    if (ibps_pkg::PEND_W'(rep_raw) > ibps_pkg::PEND_W'(ibps_pkg::TABLE_DEPTH)) begin
      rep_start = ibps_pkg::PEND_W'(ibps_pkg::TABLE_DEPTH);
    end else begin
      rep_start = ibps_pkg::PEND_W'(rep_raw);
    end
  end

  assign pos_inc   = ibps_pkg::PEND_W'(position) + 1'b1;
  assign count_inc = burst_count + 1'b1;
  assign total_inc = (total_count == '1) ? total_count : total_count + 1'b1;

  always_comb begin
    position_next    = position;
    burst_count_next = burst_count;
    total_count_next = total_count;
    led_level_next   = led_level;
    running_next     = running;
    toggled_next     = 1'b0;
    done_next        = 1'b0;
    unique case (cmd_q)
      ibps_pkg::CMD_LOAD: begin
      end
      ibps_pkg::CMD_START: begin
        if (pat_end == '0) begin
          done_next      = running;
          led_level_next = 1'b0;
          running_next   = 1'b0;
        end else begin
          position_next    = '0;
          burst_count_next = '0;
          total_count_next = '0;
          led_level_next   = 1'b1;
          running_next     = 1'b1;
        end
      end
      ibps_pkg::CMD_TICK: begin
        if (running) begin
          total_count_next = total_inc;
          burst_count_next = count_inc;
          if (count_inc == entry) begin
            led_level_next   = !led_level;
            toggled_next     = 1'b1;
            burst_count_next = '0;
            position_next    = pos_inc[ibps_pkg::ADDR_W-1:0];
            // Past the end of the pattern: wrap to the repeat part and check
            // whether sending should end at this boundary.
            if (pos_inc >= pat_end) begin
              if (rep_start < pat_end) begin
                position_next = rep_start[ibps_pkg::ADDR_W-1:0];
              end else begin
                position_next = '0;
              end
              if ((rep_start >= pat_end) || (total_inc > cfg.stop_limit)) begin
                led_level_next = 1'b0;
                running_next   = 1'b0;
                done_next      = 1'b1;
              end
            end
          end
        end
      end
      ibps_pkg::CMD_STOP: begin
        if (running) begin
          led_level_next = 1'b0;
          running_next   = 1'b0;
          done_next      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      burst_count <= '0;
      total_count <= '0;
      led_level   <= 1'b0;
      running     <= 1'b0;
    end else if (ctl.exec) begin
      position    <= position_next;
      burst_count <= burst_count_next;
      total_count <= total_count_next;
      led_level   <= led_level_next;
      running     <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      led_on   <= led_level_next;
      busy_res <= running_next;
      toggled  <= toggled_next;
      done_res <= done_next;
    end
  end

endmodule

[rtl/ir_burst_pair_sequencer.sv]
// Top level of the IR burst pair sequencer: register port, controller and datapath.
//
// The block plays an IR mark/space pattern from a table of burst durations.
// Input transactions carry cmd (load, start, tick, stop), slot and duration
// on a valid/stall channel; every input transaction yields exactly one result
// transaction (led_on, busy_res, toggled, done_res) on a valid/stall channel.
// Registers intro_pairs, repeat_pairs and stop_limit sit on an APB-style port
// at byte addresses 0, 4 and 8; write them only while the block is idle.
// Each item goes through capture, a registered read of the burst table at the
// current position, then the update; the result is registered, and a new item
// is taken only once the update of the last one is done.
// A waiting result does not hold up acceptance of the next item; only when
// the receiver stalls and the result register is still full does the update
// wait, and the input stays stalled until that result is taken.
// Reset clears the counters, the LED and the running flag and loads the
// register defaults; the table holds no defined data until it is loaded.
module ir_burst_pair_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ibps_pkg::PADDR_W-1:0]   paddr,
  input  logic [ibps_pkg::PDATA_W-1:0]   pwdata,
  output logic [ibps_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [ibps_pkg::SLOT_W-1:0]    slot,
  input  logic [ibps_pkg::DUR_W-1:0]     duration,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           led_on,
  output logic                           busy_res,
  output logic                           toggled,
  output logic                           done_res
);

  ibps_pkg::ctl_cmd_t  ctl;
  ibps_pkg::cfg_wr_t   cfg_wr;
  ibps_pkg::cfg_regs_t cfg;
  ibps_pkg::reg_idx_t  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = ibps_pkg::reg_idx_t'(paddr[3:2]);

  assign cfg_wr.we   = psel && penable && pwrite && pready;
  assign cfg_wr.idx  = reg_idx;
  assign cfg_wr.data = pwdata;

  always_comb begin
    unique case (reg_idx)
      ibps_pkg::REG_INTRO:  prdata = ibps_pkg::PDATA_W'(cfg.intro_pairs);
      ibps_pkg::REG_REPEAT: prdata = ibps_pkg::PDATA_W'(cfg.repeat_pairs);
      ibps_pkg::REG_LIMIT:  prdata = cfg.stop_limit;
      default:              prdata = '0;
    endcase
  end

  ibps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  ibps_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cfg_wr   (cfg_wr),
    .cfg      (cfg),
    .cmd      (cmd),
    .slot     (slot),
    .duration (duration),
    .led_on   (led_on),
    .busy_res (busy_res),
    .toggled  (toggled),
    .done_res (done_res)
  );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the IR burst pair sequencer: directed items, random traffic, predictor, checker.
module tb_top;
  import ibps_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int TICK_RUN_MAX = 800;

  typedef struct {
    cmd_t        c;
    logic [7:0]  s;
    logic [15:0] d;
  } ir_item_t;

  typedef struct packed {
    logic led;
    logic busy;
    logic tog;
    logic done;
  } gate_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic [SLOT_W-1:0] slot = '0;
  logic [DUR_W-1:0] duration = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic led_on;
  logic busy_res;
  logic toggled;
  logic done_res;

  ir_burst_pair_sequencer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .slot(slot), .duration(duration),
    .out_valid(out_valid), .out_stall(out_stall),
    .led_on(led_on), .busy_res(busy_res), .toggled(toggled), .done_res(done_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be driven and gate states waiting to come back.
  ir_item_t  pending_items[$];
  gate_res_t expected_gate[$];
  ir_item_t  cur_item;

  // Predictor copy of the sequencer.
  logic [15:0] pat_dur[TABLE_DEPTH];
  int          pat_pos = 0;
  logic [15:0] pat_cnt = '0;
  logic [31:0] pat_total = '0;
  logic        pat_led = 1'b0;
  logic        pat_run = 1'b0;
  int          cfg_intro = 0;
  int          cfg_repeat = 0;
  logic [31:0] cfg_limit = STOP_LIMIT_RST;

  // What the stimulus side has put into the table, used to keep reads on written slots.
  logic [15:0] gen_dur[TABLE_DEPTH];
  bit          gen_written[TABLE_DEPTH];
  int          dirty_slots[$];
  int          gen_cnt = 0;

  int err_cnt = 0;
  int n_in = 0;
  int n_out = 0;
  int n_tog = 0;
  int n_done = 0;
  int n_start = 0;
  int n_settings = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_wait = 0;
  bit in_fire = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  function automatic int pattern_end();
    int e;
    e = 2 * (cfg_intro + cfg_repeat);
    return (e > TABLE_DEPTH) ? TABLE_DEPTH : e;
  endfunction

  function automatic gate_res_t advance_pattern(ir_item_t it);
    int pend;
    int rstart;
    logic [15:0] dur_now;
    gate_res_t r;
    pend = pattern_end();
    rstart = (2 * cfg_intro > TABLE_DEPTH) ? TABLE_DEPTH : 2 * cfg_intro;
    r = '0;
    case (it.c)
      CMD_LOAD: begin
        if (it.s < TABLE_DEPTH) pat_dur[it.s] = it.d;
      end
      CMD_START: begin
        if (pend == 0) begin
          r.done = pat_run;
          pat_led = 1'b0;
          pat_run = 1'b0;
        end else begin
          pat_pos = 0;
          pat_cnt = '0;
          pat_total = '0;
          pat_led = 1'b1;
          pat_run = 1'b1;
        end
      end
      CMD_TICK: begin
        if (pat_run) begin
          if (pat_total != '1) pat_total = pat_total + 1;
          pat_cnt = pat_cnt + 16'd1;
          dur_now = (pat_pos < TABLE_DEPTH) ? pat_dur[pat_pos] : 16'd0;
          if (pat_cnt == dur_now) begin
            pat_led = !pat_led;
            r.tog = 1'b1;
            pat_cnt = '0;
            pat_pos++;
            if (pat_pos >= pend) begin
              pat_pos = (rstart < pend) ? rstart : 0;
              // An empty repeat part or an exhausted tick budget ends the send here.
              if (rstart >= pend || pat_total > cfg_limit) begin
                pat_led = 1'b0;
                pat_run = 1'b0;
                r.done = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        if (pat_run) begin
          pat_led = 1'b0;
          pat_run = 1'b0;
          r.done = 1'b1;
        end
      end
    endcase
    r.led = pat_led;
    r.busy = pat_run;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Input driver: a new transaction is presented at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_fire) begin
        // Stalled transaction stays on the port unchanged.
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        cmd <= cur_item.c;
        slot <= cur_item.s;
        duration <= cur_item.d;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      in_fire = 1'b0;
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    out_stall <= (out_wait > 0);
    if (out_wait > 0) out_wait--;
  end

  // Monitor: predicts on accepted input and checks accepted results.
  always @(posedge clk) begin : monitor
    gate_res_t want;
    bit acc_in;
    bit acc_out;
    acc_in = in_valid && !in_stall;
    acc_out = out_valid && !out_stall;
    if (!rst) begin
      if (acc_in) begin
        expected_gate.push_back(advance_pattern(cur_item));
        if (cur_item.c == CMD_START) n_start++;
        n_in++;
        in_fire = 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = draw_wait(in_calm);
      end
      if (acc_out) begin
        n_out++;
        n_tog += toggled;
        n_done += done_res;
        if (expected_gate.size() == 0) begin
          note_mismatch("result with nothing expected", 32'h0,
                        {28'h0, led_on, busy_res, toggled, done_res});
        end else begin
          want = expected_gate.pop_front();
          if (led_on !== want.led) note_mismatch("led_on", want.led, led_on);
          if (busy_res !== want.busy) note_mismatch("busy_res", want.busy, busy_res);
          if (toggled !== want.tog) note_mismatch("toggled", want.tog, toggled);
          if (done_res !== want.done) note_mismatch("done_res", want.done, done_res);
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_wait = draw_wait(out_calm);
      end
      if (acc_in || acc_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_INTRO: begin
        cfg_intro = int'(val[6:0]);
        want = {25'h0, val[6:0]};
      end
      REG_REPEAT: begin
        cfg_repeat = int'(val[6:0]);
        want = {25'h0, val[6:0]};
      end
      default: begin
        cfg_limit = val;
        want = val;
      end
    endcase
    // Read back what was just written.
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== want) note_mismatch("register readback", want, rd);
  endtask

  task automatic push_item(cmd_t c, int s, int d);
    ir_item_t it;
    it.c = c;
    it.s = s[7:0];
    it.d = d[15:0];
    if (c == CMD_LOAD) begin
      gen_dur[s] = d[15:0];
      gen_written[s] = 1'b1;
    end
    pending_items.push_back(it);
    gen_cnt++;
  endtask

  task automatic push_cmd(cmd_t c);
    push_item(c, $urandom_range(0, 255), $urandom_range(0, 65535));
  endtask

  // A load with any duration; odd values landing inside the pattern are undone later.
  task automatic load_noise(int pend);
    int s;
    int d;
    s = $urandom_range(0, 255);
    case ($urandom_range(0, 7))
      0: d = 0;
      1: d = 65535;
      2: d = $urandom_range(0, 65535);
      default: d = $urandom_range(1, 4);
    endcase
    if (s < pend && (d == 0 || d > 4)) dirty_slots.push_back(s);
    push_item(CMD_LOAD, s, d);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_gate.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_setting(int intro, int rep, logic [31:0] lim, int budget);
    int pend;
    int base;
    int plen;
    int k;
    int x;
    wait_drained();
    reg_write(REG_INTRO, ($urandom() & 32'hFFFF_FF80) | intro);
    reg_write(REG_REPEAT, ($urandom() & 32'hFFFF_FF80) | rep);
    reg_write(REG_LIMIT, lim);
    n_settings++;
    pend = pattern_end();
    base = gen_cnt;
    // Every slot the pattern can read gets a short, defined duration first.
    for (int s = 0; s < pend; s++)
      if (!gen_written[s] || gen_dur[s] == 0 || gen_dur[s] > 4)
        push_item(CMD_LOAD, s, $urandom_range(1, 4));
    while (gen_cnt - base < budget) begin
      x = $urandom_range(0, 99);
      if (x < 70) begin
        while (dirty_slots.size() > 0)
          push_item(CMD_LOAD, dirty_slots.pop_front(), $urandom_range(1, 4));
        push_cmd(CMD_START);
        plen = 0;
        for (int s = 0; s < pend; s++) plen += (gen_dur[s] == 0) ? 4 : int'(gen_dur[s]);
        k = $urandom_range(1, plen + plen / 2 + 4);
        if (k > TICK_RUN_MAX) k = TICK_RUN_MAX;
        // Keep the run inside what is left of this setting's share of items.
        if (k > budget - (gen_cnt - base)) k = budget - (gen_cnt - base);
        if (k < 1) k = 1;
        for (int i = 0; i < k; i++) begin
          x = $urandom_range(0, 99);
          if (x < 3) load_noise(pend);
          else if (x < 4) push_cmd(CMD_STOP);
          else if (x < 5) push_cmd(CMD_START);
          else push_cmd(CMD_TICK);
        end
      end else if (x < 85) begin
        load_noise(pend);
      end else begin
        x = $urandom_range(0, 3);
        if (x == CMD_LOAD) load_noise(pend);
        else push_cmd(cmd_t'(x));
      end
    end
  endtask

  initial begin
    int ph_intro[9];
    int ph_repeat[9];
    logic [31:0] ph_limit[9];
    int ph_budget[9];
    ph_intro = '{0, 1, 0, 2, 127, 3, 64, 127, 0};
    ph_repeat = '{0, 2, 3, 0, 127, 2, 64, 0, 127};
    ph_limit = '{32'd0, 32'd40000, 32'd20, 32'hFFFF_FFFF, 32'd30, 32'd0, 32'd1000,
                 32'd500, 32'hFFFF_FFFF};
    ph_budget = '{60, 120, 120, 120, 600, 120, 160, 100, 120};
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      pat_dur[s] = '0;
      gen_dur[s] = '0;
      gen_written[s] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle items, table extremes, a short pattern that stops on the limit,
    // a restart, a load while sending and a stop while sending.
    reg_write(REG_INTRO, 32'd1);
    reg_write(REG_REPEAT, 32'd1);
    reg_write(REG_LIMIT, 32'd3);
    n_settings++;
    push_item(CMD_TICK, 255, 65535);
    push_item(CMD_STOP, 0, 0);
    push_item(CMD_LOAD, 255, 65535);
    push_item(CMD_LOAD, 254, 0);
    push_item(CMD_LOAD, 0, 1);
    push_item(CMD_LOAD, 1, 2);
    push_item(CMD_LOAD, 2, 1);
    push_item(CMD_LOAD, 3, 3);
    push_item(CMD_START, 0, 0);
    push_item(CMD_TICK, 0, 0);
    push_item(CMD_TICK, 0, 0);
    push_item(CMD_START, 0, 0);
    for (int i = 0; i < 7; i++) push_item(CMD_TICK, 0, 0);
    push_item(CMD_TICK, 0, 0);
    push_item(CMD_START, 0, 0);
    push_item(CMD_TICK, 0, 0);
    push_item(CMD_LOAD, 0, 5);
    push_item(CMD_STOP, 0, 0);

    for (int p = 0; p < 9; p++)
      run_setting(ph_intro[p], ph_repeat[p], ph_limit[p], ph_budget[p]);

    wait_drained();
    repeat (12) @(posedge clk);
    $display("covered %0d input transactions and %0d results over %0d register settings",
             n_in, n_out, n_settings);
    $display("%0d starts, %0d burst ends, %0d sends ended; %0d mismatches",
             n_start, n_tog, n_done, err_cnt);
    if (err_cnt == 0 && expected_gate.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ibps_pkg.sv
rtl/ibps_ctrl.sv
rtl/ibps_dp.sv
rtl/ir_burst_pair_sequencer.sv
bench/tb_top.sv
